// ===== design/memory_commit_quota_guard_defines.svh =====
// Assertion macros shared by the quota guard RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MEMORY_COMMIT_QUOTA_GUARD_DEFINES_SVH
`define MEMORY_COMMIT_QUOTA_GUARD_DEFINES_SVH

// Check on every rising edge outside of reset.
`define MCQG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every rising edge, reset included.
`define MCQG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== design/mcqg_pkg.sv =====
// Package for the memory commit quota guard: field widths, command codes,
// reset values and default sizes. No dependencies.
`timescale 1ns / 1ps

package mcqg_pkg;

  localparam int FIELD_W = 48;
  localparam int TAG_W   = 64;
  localparam int PID_W   = 22;
  localparam int CNT_W   = 32;
  localparam int CMD_W   = 2;

  localparam int TABLE_DEPTH_DEF  = 4096;
  localparam int ADDRESS_BITS_DEF = 48;

  // Largest break jump that still counts as a change (1 GiB).
  localparam logic [FIELD_W-1:0] JUMP_LIMIT = FIELD_W'(64'd1 << 30);
  // Hard cap after reset (450 MiB).
  localparam logic [FIELD_W-1:0] CAP_RESET  = FIELD_W'(64'd471859200);

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP   = 2'd0,
    CMD_BRK   = 2'd1,
    CMD_REMAP = 2'd2
  } cmd_e;

endpackage

// ===== design/memory_commit_quota_guard.sv =====
// Top level of the memory commit quota guard: request decode, running total,
// counters, break baseline table. Uses mcqg_pkg, mcqg_ram, mcqg_slot_mod.
`timescale 1ns / 1ps
`include "memory_commit_quota_guard_defines.svh"

//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------------
//  request   | in        | in_valid_i / in_ready_o | cmd, tag, pid, map, break, sizes
//  result    | out       | out_valid_o/out_ready_i | tag, denied, total, counts
//  config    | in        | cfg_we_i (no wait)      | cfg_wdata_i = hard cap
//
//  One request at a time. With a power-of-two table depth the accept edge launches
//  the baseline table read, and the execute state then applies the update, writes
//  the table back and loads the result register. Other depths first wait out the
//  two-stage slot reciprocal and then launch the read for break moves with a
//  nonzero break. The table read-modify-write sets this sequence.
//  After reset the table is swept to zero, one entry a cycle, with in_ready_o low.
//  A stalled result register holds the request in its execute cycle; a new request
//  is still taken while a result waits.

module memory_commit_quota_guard
  import mcqg_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config
  input  logic               cfg_we_i,
  input  logic [FIELD_W-1:0] cfg_wdata_i,
  // request
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [TAG_W-1:0]   request_tag_i,
  input  logic [PID_W-1:0]   process_id_i,
  input  logic [FIELD_W-1:0] map_length_i,
  input  logic [FIELD_W-1:0] new_break_i,
  input  logic [FIELD_W-1:0] old_size_i,
  input  logic [FIELD_W-1:0] new_size_i,
  // result
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [TAG_W-1:0]   request_tag_out_o,
  output logic               denied_o,
  output logic [FIELD_W-1:0] committed_total_o,
  output logic [CNT_W-1:0]   request_count_o,
  output logic [CNT_W-1:0]   deny_count_o
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // Stored break width: breaks are taken modulo 2^ADDRESS_BITS
  localparam int BRK_W = (ADDRESS_BITS < FIELD_W) ? ADDRESS_BITS : FIELD_W;
  localparam bit POW2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_EXEC  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic               mod_cnt_q, mod_cnt_d;
  logic [IDX_W-1:0]   slot_q, slot_d;

  // request held for execution
  logic [TAG_W-1:0]   tag_q;
  logic               is_brk_q, grow_q, shrink_q;
  logic [FIELD_W-1:0] mag_q;
  logic [BRK_W-1:0]   brk_q;
  logic [PID_W-1:0]   pid_q;

  logic [FIELD_W-1:0] cap_q;
  logic [FIELD_W-1:0] total_q, total_d;
  logic [CNT_W-1:0]   req_cnt_q, deny_cnt_q;

  logic               out_valid_q;
  logic [TAG_W-1:0]   out_tag_q;
  logic               out_denied_q;
  logic [FIELD_W-1:0] out_total_q;
  logic [CNT_W-1:0]   out_req_q, out_deny_q;

  // decode on accept
  logic               accept;
  logic [BRK_W-1:0]   brk_in;
  logic               acc_is_brk, acc_grow, acc_shrink;
  logic [FIELD_W-1:0] acc_mag;

  // table port
  logic [PID_W-1:0]   slot_pid;
  logic [IDX_W-1:0]   slot_calc;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [BRK_W-1:0]   ram_wdata, prev_brk;

  // execute
  logic               out_free, exec_go;
  logic               brk_up, brk_ok;
  logic [BRK_W-1:0]   brk_diff;
  logic               eff_grow, eff_shrink;
  logic [FIELD_W-1:0] eff_mag;
  logic [FIELD_W:0]   grown;
  logic               deny_w;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign exec_go    = (state_q == ST_EXEC) && out_free;

  // ---------------------------------------------------------------------------
  // Decode the request kind into a signed change where it is known up front
  // ---------------------------------------------------------------------------
  assign brk_in     = new_break_i[BRK_W-1:0];
  assign acc_is_brk = (cmd_i == CMD_BRK) && (brk_in != '0);

  always_comb begin
    acc_grow   = 1'b0;
    acc_shrink = 1'b0;
    acc_mag    = '0;
    unique case (cmd_i)
      CMD_MAP: begin
        acc_grow = (map_length_i != '0);
        acc_mag  = map_length_i;
      end
      CMD_REMAP: begin
        acc_grow   = new_size_i > old_size_i;
        acc_shrink = new_size_i < old_size_i;
        acc_mag    = acc_grow ? (new_size_i - old_size_i) : (old_size_i - new_size_i);
      end
      default: begin
        // break moves are resolved after the table read; unused code is a no-op
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Slot of the break table. Power-of-two depths index straight from the port.
  // ---------------------------------------------------------------------------
  assign slot_pid = POW2 ? process_id_i : pid_q;

  mcqg_slot_mod #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_slot (
    .clk_i (clk_i),
    .pid_i (slot_pid),
    .slot_o(slot_calc)
  );

  // ---------------------------------------------------------------------------
  // Control sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    mod_cnt_d = mod_cnt_q;
    slot_d    = slot_q;
    ram_re    = 1'b0;
    ram_raddr = slot_calc;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (POW2) begin
            // launch the baseline read with the accept
            ram_re  = 1'b1;
            slot_d  = slot_calc;
            state_d = ST_EXEC;
          end else if (acc_is_brk) begin
            mod_cnt_d = 1'b0;
            state_d   = ST_MOD;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_MOD: begin
        // wait out the reciprocal stages
        mod_cnt_d = 1'b1;
        if (mod_cnt_q) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        slot_d  = slot_calc;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      mod_cnt_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      mod_cnt_q <= mod_cnt_d;
    end
  end

  // Hold the request for the execute step
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (accept) begin
      tag_q    <= request_tag_i;
      is_brk_q <= acc_is_brk;
      grow_q   <= acc_grow;
      shrink_q <= acc_shrink;
      mag_q    <= acc_mag;
      brk_q    <= brk_in;
      pid_q    <= process_id_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Break baseline table. The next read is only launched after the write-back
  // edge, so a read never overlaps a pending write to the same entry.
  // ---------------------------------------------------------------------------
  assign ram_we    = (state_q == ST_CLEAR) || (exec_go && is_brk_q);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : slot_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : brk_q;

  mcqg_ram #(
    .WIDTH(BRK_W),
    .DEPTH(TABLE_DEPTH)
  ) u_brk_tbl (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(prev_brk)
  );

  // ---------------------------------------------------------------------------
  // Execute: resolve the break change, check the cap, update the total
  // ---------------------------------------------------------------------------
  assign brk_up   = brk_q > prev_brk;
  assign brk_diff = brk_up ? (brk_q - prev_brk) : (prev_brk - brk_q);
  // unset baseline or a jump past the limit only rebases
  assign brk_ok   = (prev_brk != '0) && (FIELD_W'(brk_diff) <= JUMP_LIMIT);

  assign eff_grow   = is_brk_q ? (brk_ok && brk_up) : grow_q;
  assign eff_shrink = is_brk_q ? (brk_ok && !brk_up) : shrink_q;
  assign eff_mag    = is_brk_q ? FIELD_W'(brk_diff) : mag_q;

  assign grown  = {1'b0, total_q} + {1'b0, eff_mag};
  assign deny_w = eff_grow && (grown > {1'b0, cap_q});

  always_comb begin
    total_d = total_q;
    priority if (eff_grow && !deny_w) begin
      total_d = grown[FIELD_W-1:0];
    end else if (eff_shrink) begin
      // saturate at zero
      total_d = (total_q > eff_mag) ? (total_q - eff_mag) : '0;
    end else begin
      // denied growth or no change: hold the total
      total_d = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CAP_RESET;
      total_q    <= '0;
      req_cnt_q  <= '0;
      deny_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (exec_go) begin
        total_q    <= total_d;
        req_cnt_q  <= req_cnt_q + CNT_W'(1);
        deny_cnt_q <= deny_cnt_q + CNT_W'(deny_w);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on execute, drop on transfer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_tag_q    <= tag_q;
      out_denied_q <= deny_w;
      out_total_q  <= total_d;
      out_req_q    <= req_cnt_q + CNT_W'(1);
      out_deny_q   <= deny_cnt_q + CNT_W'(deny_w);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign request_tag_out_o = out_tag_q;
  assign denied_o          = out_denied_q;
  assign committed_total_o = out_total_q;
  assign request_count_o   = out_req_q;
  assign deny_count_o      = out_deny_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MCQG_ASSERT_ALWAYS(a_no_accept_in_clear, (state_q == ST_CLEAR) |-> !in_ready_o,
                      "request taken during table clear")
  `MCQG_ASSERT(a_tbl_write_phase,
               ram_we |-> ((state_q == ST_CLEAR) || (state_q == ST_EXEC)),
               "table written outside clear or execute")
  `MCQG_ASSERT(a_cap_respected, (exec_go && eff_grow && !deny_w) |=> (total_q <= cap_q),
               "admitted growth exceeds the cap")
  `MCQG_ASSERT(a_deny_count,
               exec_go |=> (deny_cnt_q == $past(deny_cnt_q) + CNT_W'(denied_o)),
               "deny count out of step with result")

endmodule

// ===== design/mcqg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the break baseline table.
`timescale 1ns / 1ps

module mcqg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mcqg_slot_mod.sv =====
// Table slot from a process id: the id modulo the table depth.
// Uses mcqg_pkg. A mask for power-of-two depths, else a two-stage reciprocal.
`timescale 1ns / 1ps

module mcqg_slot_mod
  import mcqg_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic [PID_W-1:0] pid_i,
  output logic [IDX_W-1:0] slot_o
);

  localparam bit POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  if (TABLE_DEPTH == 1) begin : g_single
    assign slot_o = '0;
  end else if (POW2) begin : g_mask
    assign slot_o = pid_i[IDX_W-1:0];
  end else begin : g_recip
    // floor(2^PID_W / depth); the quotient estimate is low by at most one
    localparam logic [PID_W:0]   RECIP = (PID_W + 1)'((64'd1 << PID_W) / TABLE_DEPTH);
    localparam logic [PID_W-1:0] DIV   = PID_W'(TABLE_DEPTH);

    logic [2*PID_W:0]   prod_q;
    logic [2*PID_W-1:0] qd_full;
    logic [PID_W-1:0]   qd_q;
    logic [PID_W-1:0]   rem;

    assign qd_full = prod_q[2*PID_W-1:PID_W] * DIV;

    // Stage 1: quotient estimate; stage 2: back-multiply
    always_ff @(posedge clk_i) begin
      prod_q <= pid_i * RECIP;
      qd_q   <= qd_full[PID_W-1:0];
    end

    // Remainder lies below twice the depth: one correction step
    assign rem    = pid_i - qd_q;
    assign slot_o = (rem >= DIV) ? IDX_W'(rem - DIV) : IDX_W'(rem);
  end

endmodule

// ===== bench/memory_commit_quota_guard_tb.sv =====
// Self-checking bench for memory_commit_quota_guard: directed and random commit
// requests with random gaps and result stalls, checked against an in-bench predictor.
// Depends on mcqg_pkg and the memory_commit_quota_guard RTL only.
`timescale 1ns / 1ps

module memory_commit_quota_guard_tb;
  import mcqg_pkg::*;

  // The fourth command code has no name in the package; the block counts it and
  // otherwise leaves everything alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [FIELD_W-1:0] MIB       = 48'd1048576;
  localparam logic [FIELD_W-1:0] BRK_START = 48'h0000_4000_0000;
  localparam logic [FIELD_W-1:0] ALL_ONES  = {FIELD_W{1'b1}};
  localparam int                 ANCHORS   = 8;
  // Covers the table sweep after reset plus the longest gap and stall.
  localparam int                 STALL_LIMIT = 20000;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [TAG_W-1:0]   tag;
    logic [PID_W-1:0]   process_id;
    logic [FIELD_W-1:0] map_length;
    logic [FIELD_W-1:0] new_break;
    logic [FIELD_W-1:0] old_size;
    logic [FIELD_W-1:0] new_size;
  } commit_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               denied;
    logic [FIELD_W-1:0] total;
    logic [CNT_W-1:0]   requests;
    logic [CNT_W-1:0]   denials;
  } verdict_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [FIELD_W-1:0] cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic [CMD_W-1:0]   cmd_i         = CMD_MAP;
  logic [TAG_W-1:0]   request_tag_i = '0;
  logic [PID_W-1:0]   process_id_i  = '0;
  logic [FIELD_W-1:0] map_length_i  = '0;
  logic [FIELD_W-1:0] new_break_i   = '0;
  logic [FIELD_W-1:0] old_size_i    = '0;
  logic [FIELD_W-1:0] new_size_i    = '0;
  logic               out_ready_i   = 1'b0;

  logic               in_ready_o;
  logic               out_valid_o;
  logic [TAG_W-1:0]   request_tag_out_o;
  logic               denied_o;
  logic [FIELD_W-1:0] committed_total_o;
  logic [CNT_W-1:0]   request_count_o;
  logic [CNT_W-1:0]   deny_count_o;

  always #5 clk_i = ~clk_i;

  memory_commit_quota_guard DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .request_tag_i     (request_tag_i),
    .process_id_i      (process_id_i),
    .map_length_i      (map_length_i),
    .new_break_i       (new_break_i),
    .old_size_i        (old_size_i),
    .new_size_i        (new_size_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .request_tag_out_o (request_tag_out_o),
    .denied_o          (denied_o),
    .committed_total_o (committed_total_o),
    .request_count_o   (request_count_o),
    .deny_count_o      (deny_count_o)
  );

  // ---------------------------------------------------------------------------
  // Quota predictor: its own copy of the cap, the running total, the break
  // baselines and both counters.
  // ---------------------------------------------------------------------------
  logic [FIELD_W-1:0] model_cap;
  logic [FIELD_W-1:0] model_total;
  logic [FIELD_W-1:0] brk_base [TABLE_DEPTH_DEF];
  logic [CNT_W-1:0]   model_seen;
  logic [CNT_W-1:0]   model_denied;

  commit_req_t req_backlog[$];       // requests waiting for the driver
  verdict_t    expected_verdicts[$]; // predicted results, oldest first

  logic               in_xfer_q = 1'b0; // request transfer at the last rising edge
  int unsigned        send_gap  = 0;
  int unsigned        hold_off  = 0;
  logic               steady    = 1'b0; // no idling while set
  int unsigned        mismatches   = 0;
  int unsigned        stall_cycles = 0;
  logic [FIELD_W-1:0] brk_anchor [ANCHORS];

  // Signed change that a break move makes; a nonzero break updates the baseline of its slot.
  function automatic longint break_shift(logic [PID_W-1:0] pid, logic [FIELD_W-1:0] brk);
    int unsigned        slot;
    logic [FIELD_W-1:0] prev;
    longint             diff;
    longint             jump;
    slot = pid % TABLE_DEPTH_DEF;
    jump = longint'({{(64-FIELD_W){1'b0}}, JUMP_LIMIT});
    if (brk == '0) return 0;   // query only
    prev = brk_base[slot];
    brk_base[slot] = brk;
    if (prev == '0) return 0;  // first break just sets the baseline
    diff = longint'({{(64-FIELD_W){1'b0}}, brk}) - longint'({{(64-FIELD_W){1'b0}}, prev});
    if (diff > jump || diff < -jump) return 0;
    return diff;
  endfunction

  function automatic verdict_t judge_request(commit_req_t rq);
    longint             delta;
    logic [FIELD_W:0]   grown;
    logic [FIELD_W-1:0] mag;
    verdict_t           v;
    delta    = 0;
    v.denied = 1'b0;
    model_seen = model_seen + 1'b1;
    case (rq.cmd)
      CMD_MAP:   delta = longint'({{(64-FIELD_W){1'b0}}, rq.map_length});
      CMD_BRK:   delta = break_shift(rq.process_id, rq.new_break);
      CMD_REMAP: delta = longint'({{(64-FIELD_W){1'b0}}, rq.new_size}) -
                         longint'({{(64-FIELD_W){1'b0}}, rq.old_size});
      default:   delta = 0;
    endcase
    if (delta > 0) begin
      // Growth past the cap is refused and leaves the total alone.
      grown = {1'b0, model_total} + delta[FIELD_W:0];
      if (grown > {1'b0, model_cap}) begin
        v.denied     = 1'b1;
        model_denied = model_denied + 1'b1;
      end else begin
        model_total = grown[FIELD_W-1:0];
      end
    end else if (delta < 0) begin
      // Shrink, saturating at zero.
      mag = FIELD_W'(-delta);
      model_total = (model_total > mag) ? model_total - mag : '0;
    end
    v.tag      = rq.tag;
    v.total    = model_total;
    v.requests = model_seen;
    v.denials  = model_denied;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [FIELD_W-1:0] rand48();
    return FIELD_W'({$urandom, $urandom});
  endfunction

  // Mostly short gaps, a few long ones; stretches with none at all.
  function automatic int unsigned gap_cycles();
    int unsigned r;
    if ($urandom_range(0, 99) < 3) steady = !steady;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sizes scaled to the current cap so both admits and denials show up.
  function automatic logic [FIELD_W-1:0] pick_size(logic [FIELD_W-1:0] scale);
    int unsigned r;
    logic [63:0] span;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      span = {{(64-FIELD_W){1'b0}}, scale >> 2} + 64'd1;
      return FIELD_W'({{(64-FIELD_W){1'b0}}, rand48()} % span);
    end
    if (r < 75) return FIELD_W'($urandom_range(0, 65536));
    if (r < 90) begin
      span = {{(64-FIELD_W){1'b0}}, scale} + 64'd1;
      return FIELD_W'({{(64-FIELD_W){1'b0}}, rand48()} % span);
    end
    if (r < 97) return rand48();
    return ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
  endfunction

  // Every field random; the caller overrides the ones the command uses.
  function automatic commit_req_t noise_req();
    commit_req_t rq;
    rq.cmd        = CMD_W'($urandom);
    rq.tag        = {$urandom, $urandom};
    rq.process_id = PID_W'($urandom);
    rq.map_length = rand48();
    rq.new_break  = rand48();
    rq.old_size   = rand48();
    rq.new_size   = rand48();
    return rq;
  endfunction

  // Queue one request; a goes to the length, break or old size, b to the new size.
  task automatic queue_req(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                           logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
    commit_req_t rq;
    rq = noise_req();
    rq.cmd        = cmd;
    rq.process_id = pid;
    case (cmd)
      CMD_MAP:   rq.map_length = a;
      CMD_BRK:   rq.new_break  = a;
      CMD_REMAP: begin
        rq.old_size = a;
        rq.new_size = b;
      end
      default: ;
    endcase
    req_backlog.push_back(rq);
  endtask

  // Random requests; break moves stay near a few per-slot anchors so that most of
  // them get past the first-break state and land inside the jump window.
  task automatic queue_random(int count, logic [FIELD_W-1:0] scale);
    commit_req_t rq;
    int unsigned r;
    int unsigned k;
    int unsigned pid_hi;
    for (int i = 0; i < count; i++) begin
      rq = noise_req();
      r  = $urandom_range(0, 99);
      rq.cmd = (r < 30) ? CMD_MAP : (r < 65) ? CMD_BRK : (r < 95) ? CMD_REMAP : CMD_UNUSED;
      rq.map_length = pick_size(scale);
      rq.old_size   = pick_size(scale);
      rq.new_size   = pick_size(scale);
      if (rq.cmd == CMD_BRK) begin
        k      = $urandom_range(0, ANCHORS - 1);
        pid_hi = $urandom;
        rq.process_id = PID_W'(pid_hi * TABLE_DEPTH_DEF + k * 509 + 7);
        r = $urandom_range(0, 99);
        if (r < 3) brk_anchor[k] = rand48();
        if (r < 10)      rq.new_break = '0;
        else if (r < 15) rq.new_break = rand48();
        else if (r < 25) rq.new_break = brk_anchor[k] + FIELD_W'($urandom_range(0, 32'hBFFF_FFFF));
        else             rq.new_break = brk_anchor[k] + FIELD_W'($urandom_range(0, 600 * 1048576));
      end
      req_backlog.push_back(rq);
    end
  endtask

  // Hold until every request went out and every result came back, then let the
  // block's pipeline empty before touching the cap.
  task automatic wait_drained();
    while (req_backlog.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [FIELD_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    model_cap    = value;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge. Drop valid after a transfer,
  // wait out the gap, then launch the next queued request. Stall the result
  // side at random.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive
    logic        next_valid;
    commit_req_t nxt;
    next_valid = in_valid_i;
    if (in_xfer_q) next_valid = 1'b0;
    if (!next_valid && rst_ni) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (req_backlog.size() != 0) begin
        nxt = req_backlog.pop_front();
        cmd_i         <= nxt.cmd;
        request_tag_i <= nxt.tag;
        process_id_i  <= nxt.process_id;
        map_length_i  <= nxt.map_length;
        new_break_i   <= nxt.new_break;
        old_size_i    <= nxt.old_size;
        new_size_i    <= nxt.new_size;
        next_valid = 1'b1;
        send_gap   = gap_cycles();
      end
    end
    in_valid_i <= next_valid;

    if (hold_off != 0) begin
      out_ready_i <= 1'b0;
      hold_off--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < 25) hold_off = gap_cycles();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Check each result transfer against the
  // oldest prediction, predict each request transfer, and watch for a hang.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    commit_req_t seen;
    verdict_t    want;
    verdict_t    got;
    logic        in_fire;
    logic        out_fire;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    in_xfer_q <= in_fire;

    if (out_fire) begin
      got.tag      = request_tag_out_o;
      got.denied   = denied_o;
      got.total    = committed_total_o;
      got.requests = request_count_o;
      got.denials  = deny_count_o;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tag %h denied %0d total %0d", got.tag, got.denied,
                   got.total);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.tag !== want.tag || got.denied !== want.denied || got.total !== want.total ||
            got.requests !== want.requests || got.denials !== want.denials) begin
          mismatches++;
          // expected value first, actual second
          if (mismatches <= 10)
            $display("mismatch: tag %h/%h den %0d/%0d tot %0d/%0d req %0d/%0d dny %0d/%0d",
                     want.tag, got.tag, want.denied, got.denied, want.total, got.total,
                     want.requests, got.requests, want.denials, got.denials);
        end
      end
    end

    if (in_fire) begin
      seen.cmd        = cmd_i;
      seen.tag        = request_tag_i;
      seen.process_id = process_id_i;
      seen.map_length = map_length_i;
      seen.new_break  = new_break_i;
      seen.old_size   = old_size_i;
      seen.new_size   = new_size_i;
      expected_verdicts.push_back(judge_request(seen));
    end

    // Count cycles without any transfer; this covers the table sweep after reset.
    stall_cycles = (in_fire || out_fire) ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("memory_commit_quota_guard_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, then phases at different caps; the first two start with directed items.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    commit_req_t        rq;
    logic [FIELD_W-1:0] cap_pick;
    model_cap    = CAP_RESET;
    model_total  = '0;
    model_seen   = '0;
    model_denied = '0;
    foreach (brk_base[i]) brk_base[i] = '0;
    foreach (brk_anchor[i]) brk_anchor[i] = rand48() | (FIELD_W'(1) << 36);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase at the reset cap: extremes of every field, then the break cases.
    rq = noise_req();
    rq.cmd = CMD_MAP;
    rq.map_length = '0;               // zero change, never denied
    rq.tag = '0;
    req_backlog.push_back(rq);
    rq = noise_req();
    rq.cmd = CMD_MAP;
    rq.map_length = ALL_ONES;         // far past the cap
    rq.tag = {TAG_W{1'b1}};
    req_backlog.push_back(rq);
    queue_req(CMD_MAP,   PID_W'($urandom), 100 * MIB, '0);
    queue_req(CMD_REMAP, PID_W'($urandom), '0, 50 * MIB);
    queue_req(CMD_REMAP, PID_W'($urandom), 30 * MIB, 10 * MIB);
    queue_req(CMD_REMAP, PID_W'($urandom), 7 * MIB, 7 * MIB);
    queue_req(CMD_REMAP, PID_W'($urandom), ALL_ONES, '0);   // shrink saturates at zero
    queue_req(CMD_MAP,   PID_W'($urandom), 300 * MIB, '0);
    queue_req(CMD_UNUSED, PID_W'($urandom), '0, '0);
    queue_req(CMD_BRK, 22'd5, '0, '0);                       // query only
    queue_req(CMD_BRK, 22'd5, BRK_START, '0);                // first break
    queue_req(CMD_BRK, 22'd5, BRK_START + 100 * MIB, '0);
    queue_req(CMD_BRK, PID_W'(5 + TABLE_DEPTH_DEF), BRK_START + 60 * MIB, '0);  // same slot
    // Exactly one GiB up still counts, is refused, and moves the baseline.
    queue_req(CMD_BRK, 22'd5, BRK_START + 60 * MIB + JUMP_LIMIT, '0);
    queue_req(CMD_BRK, 22'd5, BRK_START + 60 * MIB + 2 * JUMP_LIMIT + 1, '0);
    queue_req(CMD_BRK, 22'd5, BRK_START, '0);                // large jump down
    queue_req(CMD_BRK, {PID_W{1'b1}}, ALL_ONES, '0);
    queue_req(CMD_BRK, {PID_W{1'b1}}, ALL_ONES - 20 * MIB, '0);
    queue_req(CMD_BRK, {PID_W{1'b1}}, ALL_ONES, '0);
    queue_req(CMD_REMAP, PID_W'($urandom), '0, CAP_RESET);
    queue_req(CMD_MAP,   PID_W'($urandom), 90 * MIB, '0);    // lands on the cap
    queue_req(CMD_MAP,   PID_W'($urandom), 48'd1, '0);
    queue_random(250, CAP_RESET);
    wait_drained();

    // Cap below the running total: growth refused, shrinks still apply.
    write_cap('0);
    queue_req(CMD_MAP,   PID_W'($urandom), 48'd1, '0);
    queue_req(CMD_REMAP, PID_W'($urandom), 10 * MIB, '0);
    queue_req(CMD_REMAP, PID_W'($urandom), '0, '0);
    queue_req(CMD_BRK, 22'd5, BRK_START + 4 * MIB, '0);
    queue_random(100, 64 * MIB);
    wait_drained();

    write_cap(ALL_ONES);
    queue_random(300, ALL_ONES);
    wait_drained();

    cap_pick = rand48() >> $urandom_range(8, 24);
    write_cap(cap_pick);
    queue_random(300, cap_pick);
    wait_drained();

    write_cap(CAP_RESET);
    queue_random(300, CAP_RESET);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("memory_commit_quota_guard_tb: done, clean");
    end else begin
      $display("memory_commit_quota_guard_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/mcqg_pkg.sv
design/mcqg_ram.sv
design/mcqg_slot_mod.sv
design/memory_commit_quota_guard.sv
bench/memory_commit_quota_guard_tb.sv
